// ===== rtl/spmvq_pkg.sv =====
package spmvq_pkg;

    localparam int MAX_NODES = 64;
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int CNT_W     = $clog2(MAX_NODES + 1);
    localparam int CFG_W     = 7;
    localparam int VALUE_W   = 32;
    localparam int SUM_W     = 38;
    localparam int CMD_W     = 2;

    localparam logic [CMD_W-1:0] CMD_LOAD_VALUE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_ROW   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY      = 2'd2;

    localparam logic [CFG_W-1:0] COUNT_RESET = CFG_W'(MAX_NODES);

    typedef struct packed {
        logic              valid;
        logic              first;
        logic [NODE_W-1:0] addr;
    } upd_t;

endpackage

// ===== rtl/spmvq_graph_mem.sv =====
module spmvq_graph_mem (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 value_we,
    input  logic                                 row_we,
    input  logic [spmvq_pkg::NODE_W-1:0]         waddr,
    input  logic [spmvq_pkg::VALUE_W-1:0]        wvalue,
    input  logic [spmvq_pkg::MAX_NODES-1:0]      wrow,
    input  logic [spmvq_pkg::NODE_W-1:0]         val_raddr,
    input  logic [spmvq_pkg::NODE_W-1:0]         row_raddr,
    output logic [spmvq_pkg::VALUE_W-1:0]        val_rd,
    output logic [spmvq_pkg::MAX_NODES-1:0]      row_rd
);

    logic [spmvq_pkg::VALUE_W-1:0]   value_mem [spmvq_pkg::MAX_NODES];
    logic [spmvq_pkg::MAX_NODES-1:0] row_mem   [spmvq_pkg::MAX_NODES];
    logic [spmvq_pkg::MAX_NODES-1:0] row_valid_reg;
    logic [spmvq_pkg::MAX_NODES-1:0] row_data_reg;
    logic                            row_hit_reg;
    logic [spmvq_pkg::VALUE_W-1:0]   val_data_reg;
    logic                            addr_ok;

    assign addr_ok = spmvq_pkg::CNT_W'(waddr) < spmvq_pkg::CNT_W'(spmvq_pkg::MAX_NODES);

    always_ff @(posedge clk)
    begin
        if (value_we && addr_ok)
        begin
            value_mem[waddr] <= wvalue;
        end
        if (row_we && addr_ok)
        begin
            row_mem[waddr] <= wrow;
        end
        val_data_reg <= value_mem[val_raddr];
        row_data_reg <= row_mem[row_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            row_hit_reg   <= 1'b0;
        end
        else
        begin
            if (row_we && addr_ok)
            begin
                row_valid_reg[waddr] <= 1'b1;
            end
            row_hit_reg <= row_valid_reg[row_raddr];
        end
    end

    assign val_rd = val_data_reg;
    assign row_rd = row_hit_reg ? row_data_reg : '0;

endmodule

// ===== rtl/spmvq_best_unit.sv =====
module spmvq_best_unit (
    input  logic                              clk,
    input  spmvq_pkg::upd_t                   upd,
    input  logic [spmvq_pkg::SUM_W-1:0]       base,
    input  logic [spmvq_pkg::VALUE_W-1:0]     addend,
    input  logic [spmvq_pkg::NODE_W-1:0]      raddr,
    output logic [spmvq_pkg::SUM_W-1:0]       best_rd
);

    logic [spmvq_pkg::SUM_W-1:0] best_mem [spmvq_pkg::MAX_NODES];
    logic [spmvq_pkg::SUM_W-1:0] rd_reg;
    logic [spmvq_pkg::SUM_W-1:0] cand;
    logic                        do_write;

    always_comb
    begin
        cand     = base + spmvq_pkg::SUM_W'(addend);
        do_write = upd.valid && (upd.first || (cand > rd_reg));
    end

    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            best_mem[upd.addr] <= cand;
        end
        rd_reg <= best_mem[raddr];
    end

    assign best_rd = rd_reg;

endmodule

// ===== rtl/shortest_path_max_value_query.sv =====
// Shortest-path query with largest-value tiebreak. Loads (command 0 node value,
// command 1 adjacency row) return nothing. A query (command 2) holds busy while
// it searches, N the node count in use: each BFS level sweeps all N nodes once,
// and each frontier node then scans all N candidate neighbors at one value read
// and one add-compare per cycle through the single shared sum unit. A query whose
// source or target is out of range goes straight to the output state. The result
// appears in the same cycle that busy falls, for exactly one cycle with
// result_valid high, and cannot be held off; capture it then. Write node_count
// only while busy is low.
module shortest_path_max_value_query (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [spmvq_pkg::CMD_W-1:0]          command,
    input  logic [spmvq_pkg::NODE_W-1:0]         node,
    input  logic [spmvq_pkg::NODE_W-1:0]         target,
    input  logic [spmvq_pkg::VALUE_W-1:0]        value,
    input  logic [spmvq_pkg::MAX_NODES-1:0]      row_bits,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [spmvq_pkg::CFG_W-1:0]          cfg_data,
    output logic                                 result_valid,
    output logic                                 reachable,
    output logic [spmvq_pkg::NODE_W-1:0]         hops,
    output logic [spmvq_pkg::SUM_W-1:0]          total_value
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEED,
        ST_SEED_W,
        ST_LEVEL,
        ST_U_FETCH,
        ST_U_WAIT,
        ST_V_SCAN,
        ST_V_DRAIN,
        ST_FINISH,
        ST_OUT
    } state_t;

    state_t                           state_reg, state_next;
    logic [spmvq_pkg::CFG_W-1:0]      count_reg, count_next;
    logic [spmvq_pkg::NODE_W-1:0]     src_reg, src_next;
    logic [spmvq_pkg::NODE_W-1:0]     dst_reg, dst_next;
    logic [spmvq_pkg::MAX_NODES-1:0]  visited_reg, visited_next;
    logic [spmvq_pkg::MAX_NODES-1:0]  frontier_reg, frontier_next;
    logic [spmvq_pkg::MAX_NODES-1:0]  nmask_reg, nmask_next;
    logic [spmvq_pkg::MAX_NODES-1:0]  reach_reg, reach_next;
    logic [spmvq_pkg::CNT_W-1:0]      level_reg, level_next;
    logic [spmvq_pkg::CNT_W-1:0]      u_reg, u_next;
    logic [spmvq_pkg::CNT_W-1:0]      v_reg, v_next;
    logic [spmvq_pkg::SUM_W-1:0]      base_reg, base_next;
    logic                             p_valid_reg, p_valid_next;
    logic [spmvq_pkg::NODE_W-1:0]     p_v_reg, p_v_next;
    logic [spmvq_pkg::NODE_W-1:0]     dhops_reg, dhops_next;
    logic                             rvalid_reg, rvalid_next;
    logic                             reach_out_reg, reach_out_next;
    logic [spmvq_pkg::NODE_W-1:0]     hops_reg, hops_next;
    logic [spmvq_pkg::SUM_W-1:0]      total_reg, total_next;

    logic [spmvq_pkg::CNT_W-1:0]      eff_count;
    logic [spmvq_pkg::MAX_NODES-1:0]  live;
    logic [spmvq_pkg::NODE_W-1:0]     u_idx;
    logic [spmvq_pkg::NODE_W-1:0]     v_idx;
    logic                             accept;
    logic                             value_we;
    logic                             row_we;
    logic [spmvq_pkg::NODE_W-1:0]     val_raddr;
    logic [spmvq_pkg::NODE_W-1:0]     best_raddr;
    logic [spmvq_pkg::VALUE_W-1:0]    val_rd;
    logic [spmvq_pkg::MAX_NODES-1:0]  row_rd;
    logic [spmvq_pkg::SUM_W-1:0]      best_rd;
    logic [spmvq_pkg::SUM_W-1:0]      upd_base;
    spmvq_pkg::upd_t                  upd;

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = !busy;
    assign accept    = start && !busy;
    assign value_we  = accept && (command == spmvq_pkg::CMD_LOAD_VALUE);
    assign row_we    = accept && (command == spmvq_pkg::CMD_LOAD_ROW);
    assign u_idx     = u_reg[spmvq_pkg::NODE_W-1:0];
    assign v_idx     = v_reg[spmvq_pkg::NODE_W-1:0];

    always_comb
    begin
        if (count_reg == '0)
        begin
            eff_count = spmvq_pkg::CNT_W'(1);
        end
        else if (count_reg > spmvq_pkg::CFG_W'(spmvq_pkg::MAX_NODES))
        begin
            eff_count = spmvq_pkg::CNT_W'(spmvq_pkg::MAX_NODES);
        end
        else
        begin
            eff_count = count_reg[spmvq_pkg::CNT_W-1:0];
        end
        for (int i = 0; i < spmvq_pkg::MAX_NODES; i++)
        begin
            live[i] = spmvq_pkg::CNT_W'(i) < eff_count;
        end
    end

    always_comb
    begin
        val_raddr = (state_reg == ST_SEED) ? src_reg : v_idx;
        case (state_reg)
            ST_U_FETCH: best_raddr = u_idx;
            ST_FINISH:  best_raddr = dst_reg;
            default:    best_raddr = v_idx;
        endcase
        if (state_reg == ST_SEED_W)
        begin
            upd.valid = 1'b1;
            upd.first = 1'b1;
            upd.addr  = src_reg;
            upd_base  = '0;
        end
        else
        begin
            upd.valid = p_valid_reg;
            upd.first = !nmask_reg[p_v_reg];
            upd.addr  = p_v_reg;
            upd_base  = base_reg;
        end
    end

    spmvq_graph_mem u_graph (
        .clk       (clk),
        .rst_n     (rst_n),
        .value_we  (value_we),
        .row_we    (row_we),
        .waddr     (node),
        .wvalue    (value),
        .wrow      (row_bits),
        .val_raddr (val_raddr),
        .row_raddr (u_idx),
        .val_rd    (val_rd),
        .row_rd    (row_rd)
    );

    spmvq_best_unit u_best (
        .clk     (clk),
        .upd     (upd),
        .base    (upd_base),
        .addend  (val_rd),
        .raddr   (best_raddr),
        .best_rd (best_rd)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        src_next       = src_reg;
        dst_next       = dst_reg;
        visited_next   = visited_reg;
        frontier_next  = frontier_reg;
        nmask_next     = nmask_reg;
        reach_next     = reach_reg;
        level_next     = level_reg;
        u_next         = u_reg;
        v_next         = v_reg;
        base_next      = base_reg;
        p_valid_next   = 1'b0;
        p_v_next       = p_v_reg;
        dhops_next     = dhops_reg;
        rvalid_next    = 1'b0;
        reach_out_next = reach_out_reg;
        hops_next      = hops_reg;
        total_next     = total_reg;

        if (cfg_valid && cfg_ready)
        begin
            count_next = cfg_data;
        end

        // mark first arrival at the next level
        if (p_valid_reg && !nmask_reg[p_v_reg])
        begin
            nmask_next[p_v_reg] = 1'b1;
            if (p_v_reg == dst_reg)
            begin
                dhops_next = level_reg[spmvq_pkg::NODE_W-1:0];
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (command == spmvq_pkg::CMD_QUERY))
                begin
                    src_next     = node;
                    dst_next     = target;
                    visited_next = '0;
                    if ((spmvq_pkg::CNT_W'(node) >= eff_count) ||
                        (spmvq_pkg::CNT_W'(target) >= eff_count))
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        state_next = ST_SEED;
                    end
                end
            end
            ST_SEED:
            begin
                state_next = ST_SEED_W;
            end
            ST_SEED_W:
            begin
                visited_next  = spmvq_pkg::MAX_NODES'(1) << src_reg;
                frontier_next = spmvq_pkg::MAX_NODES'(1) << src_reg;
                level_next    = spmvq_pkg::CNT_W'(1);
                dhops_next    = '0;
                state_next    = ST_LEVEL;
            end
            ST_LEVEL:
            begin
                if ((level_reg >= eff_count) || (frontier_reg == '0) || visited_reg[dst_reg])
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    nmask_next = '0;
                    u_next     = '0;
                    state_next = ST_U_FETCH;
                end
            end
            ST_U_FETCH:
            begin
                if (u_reg == eff_count)
                begin
                    visited_next  = visited_reg | nmask_reg;
                    frontier_next = nmask_reg;
                    level_next    = level_reg + spmvq_pkg::CNT_W'(1);
                    state_next    = ST_LEVEL;
                end
                else if (frontier_reg[u_idx])
                begin
                    state_next = ST_U_WAIT;
                end
                else
                begin
                    u_next = u_reg + spmvq_pkg::CNT_W'(1);
                end
            end
            ST_U_WAIT:
            begin
                reach_next = row_rd & live & ~visited_reg;
                base_next  = best_rd;
                v_next     = '0;
                state_next = ST_V_SCAN;
            end
            ST_V_SCAN:
            begin
                p_valid_next = reach_reg[v_idx];
                p_v_next     = v_idx;
                v_next       = v_reg + spmvq_pkg::CNT_W'(1);
                if ((v_reg + spmvq_pkg::CNT_W'(1)) == eff_count)
                begin
                    state_next = ST_V_DRAIN;
                end
            end
            ST_V_DRAIN:
            begin
                u_next     = u_reg + spmvq_pkg::CNT_W'(1);
                state_next = ST_U_FETCH;
            end
            ST_FINISH:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                rvalid_next    = 1'b1;
                reach_out_next = visited_reg[dst_reg];
                hops_next      = visited_reg[dst_reg] ? dhops_reg : '0;
                total_next     = visited_reg[dst_reg] ? best_rd : '0;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= spmvq_pkg::COUNT_RESET;
            src_reg       <= '0;
            dst_reg       <= '0;
            visited_reg   <= '0;
            frontier_reg  <= '0;
            nmask_reg     <= '0;
            reach_reg     <= '0;
            level_reg     <= '0;
            u_reg         <= '0;
            v_reg         <= '0;
            base_reg      <= '0;
            p_valid_reg   <= 1'b0;
            p_v_reg       <= '0;
            dhops_reg     <= '0;
            rvalid_reg    <= 1'b0;
            reach_out_reg <= 1'b0;
            hops_reg      <= '0;
            total_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            src_reg       <= src_next;
            dst_reg       <= dst_next;
            visited_reg   <= visited_next;
            frontier_reg  <= frontier_next;
            nmask_reg     <= nmask_next;
            reach_reg     <= reach_next;
            level_reg     <= level_next;
            u_reg         <= u_next;
            v_reg         <= v_next;
            base_reg      <= base_next;
            p_valid_reg   <= p_valid_next;
            p_v_reg       <= p_v_next;
            dhops_reg     <= dhops_next;
            rvalid_reg    <= rvalid_next;
            reach_out_reg <= reach_out_next;
            hops_reg      <= hops_next;
            total_reg     <= total_next;
        end
    end

    assign result_valid = rvalid_reg;
    assign reachable    = reach_out_reg;
    assign hops         = hops_reg;
    assign total_value  = total_reg;

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import spmvq_pkg::*;

    localparam logic [CMD_W-1:0] CMD_IGNORED = 2'd3;

    typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

    typedef struct packed {
        logic              reach;
        logic [NODE_W-1:0] hops;
        logic [SUM_W-1:0]  total;
    } route_t;

    typedef struct {
        row_kind_t            kind;
        logic [CMD_W-1:0]     cmd;
        logic [NODE_W-1:0]    src;
        logic [NODE_W-1:0]    dst;
        logic [VALUE_W-1:0]   value;
        logic [MAX_NODES-1:0] bits;
        bit                   known;
        logic                 reach;
        logic [NODE_W-1:0]    hops;
        logic [SUM_W-1:0]     total;
    } stim_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [CMD_W-1:0]     command;
    logic [NODE_W-1:0]    node;
    logic [NODE_W-1:0]    target;
    logic [VALUE_W-1:0]   value;
    logic [MAX_NODES-1:0] row_bits;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_W-1:0]     cfg_data;
    logic                 result_valid;
    logic                 reachable;
    logic [NODE_W-1:0]    hops;
    logic [SUM_W-1:0]     total_value;

    logic [VALUE_W-1:0]   node_val [MAX_NODES];
    logic [MAX_NODES-1:0] adj_row [MAX_NODES];
    logic [MAX_NODES-1:0] val_written;
    logic [CFG_W-1:0]     count_reg;

    route_t    route_q [$];
    stim_row_t directed_rows [26];

    int idle_pct;
    int errors;
    int n_queries;
    int n_reached;
    int n_loads;
    int n_cfg;
    int max_hops;

    shortest_path_max_value_query dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .node         (node),
        .target       (target),
        .value        (value),
        .row_bits     (row_bits),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .reachable    (reachable),
        .hops         (hops),
        .total_value  (total_value)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int live_count();
        if (count_reg == 0)
            return 1;
        if (count_reg > MAX_NODES)
            return MAX_NODES;
        return int'(count_reg);
    endfunction

    // Return the first node whose value the search reads before it was ever loaded, or -1.
    function automatic int route_search(input int src, input int dst, output route_t res);
        int                   cnt;
        int                   unseen;
        logic [MAX_NODES-1:0] live;
        logic [MAX_NODES-1:0] visited;
        logic [MAX_NODES-1:0] frontier;
        logic [MAX_NODES-1:0] nxt;
        logic [MAX_NODES-1:0] reach;
        logic [NODE_W-1:0]    hop_of [MAX_NODES];
        logic [SUM_W-1:0]     best [MAX_NODES];
        logic [SUM_W-1:0]     cand;
        cnt = live_count();
        unseen = -1;
        res = '0;
        live = (cnt >= MAX_NODES) ? '1 : ((MAX_NODES'(1) << cnt) - MAX_NODES'(1));
        if (src >= cnt || dst >= cnt)
            return -1;
        if (!val_written[src])
            unseen = src;
        visited = '0;
        visited[src] = 1'b1;
        frontier = visited;
        hop_of[src] = '0;
        best[src] = SUM_W'(node_val[src]);
        for (int level = 1; level < cnt && frontier != '0; level++)
        begin
            if (visited[dst])
                break;
            nxt = '0;
            for (int u = 0; u < cnt; u++)
            begin
                if (frontier[u])
                begin
                    reach = adj_row[u] & live & ~visited;
                    for (int v = 0; v < cnt; v++)
                    begin
                        if (reach[v])
                        begin
                            if (!val_written[v] && unseen < 0)
                                unseen = v;
                            cand = best[u] + SUM_W'(node_val[v]);
                            if (!nxt[v])
                            begin
                                nxt[v] = 1'b1;
                                hop_of[v] = NODE_W'(level);
                                best[v] = cand;
                            end
                            else if (cand > best[v])
                            begin
                                best[v] = cand;
                            end
                        end
                    end
                end
            end
            visited |= nxt;
            frontier = nxt;
        end
        if (visited[dst])
            res = '{reach: 1'b1, hops: hop_of[dst], total: best[dst]};
        return unseen;
    endfunction

    function automatic logic [VALUE_W-1:0] rand_value();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [MAX_NODES-1:0] rand_row();
        logic [MAX_NODES-1:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(4))
            0: ;
            1: r &= {$urandom, $urandom};
            2: r = r & {$urandom, $urandom} & {$urandom, $urandom};
            3: r = MAX_NODES'(1) << $urandom_range(MAX_NODES - 1);
            default: r = '1;
        endcase
        return r;
    endfunction

    function automatic int pick_node(input int cnt);
        if ($urandom_range(7) == 0)
            return $urandom_range(MAX_NODES - 1);
        return $urandom_range(cnt - 1);
    endfunction

    // Present one request, hold it until accepted, then update the model state.
    task automatic send_request(input logic [CMD_W-1:0] cmd, input int src, input int dst,
                                input logic [VALUE_W-1:0] val,
                                input logic [MAX_NODES-1:0] bits,
                                input bit known, input route_t known_res);
        route_t res;
        command = cmd;
        node = NODE_W'(src);
        target = NODE_W'(dst);
        value = val;
        row_bits = bits;
        start = 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        case (cmd)
            CMD_LOAD_VALUE:
            begin
                node_val[src] = val;
                val_written[src] = 1'b1;
                n_loads++;
            end
            CMD_LOAD_ROW:
            begin
                adj_row[src] = bits;
                n_loads++;
            end
            CMD_QUERY:
            begin
                void'(route_search(src, dst, res));
                if (known)
                    res = known_res;
                route_q = {route_q, res};
                n_queries++;
                if (res.reach)
                    n_reached++;
                if (int'(res.hops) > max_hops)
                    max_hops = int'(res.hops);
            end
            default: ;
        endcase
        @(negedge clk);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            start = 1'b0;
            repeat ($urandom_range(1, 12))
                @(negedge clk);
        end
    endtask

    // Load any value the search would read before it exists, then issue the query.
    task automatic send_query(input int src, input int dst);
        route_t res;
        int     missing;
        missing = route_search(src, dst, res);
        while (missing >= 0)
        begin
            send_request(CMD_LOAD_VALUE, missing, $urandom_range(MAX_NODES - 1), rand_value(),
                         rand_row(), 1'b0, '0);
            missing = route_search(src, dst, res);
        end
        send_request(CMD_QUERY, src, dst, rand_value(), rand_row(), 1'b0, '0);
    endtask

    task automatic random_query(input int cnt);
        int s;
        case ($urandom_range(9))
            0:
            begin
                s = $urandom_range(cnt - 1);
                send_query(s, s);
            end
            1: send_query($urandom_range(MAX_NODES - 1), $urandom_range(MAX_NODES - 1));
            default: send_query($urandom_range(cnt - 1), $urandom_range(cnt - 1));
        endcase
    endtask

    task automatic build_chain(input int cnt, input int len);
        int order [MAX_NODES];
        int j;
        int tmp;
        for (int n = 0; n < MAX_NODES; n++)
            order[n] = n;
        for (int n = cnt - 1; n > 0; n--)
        begin
            j = $urandom_range(n);
            tmp = order[n];
            order[n] = order[j];
            order[j] = tmp;
        end
        for (int n = 0; n < len; n++)
            send_request(CMD_LOAD_ROW, order[n], $urandom_range(MAX_NODES - 1), rand_value(),
                         (n < len - 1) ? (MAX_NODES'(1) << order[n + 1]) : '0, 1'b0, '0);
        send_query(order[0], order[len - 1]);
    endtask

    task automatic drain();
        start = 1'b0;
        while (route_q.size() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_count(input logic [CFG_W-1:0] v);
        cfg_data = v;
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        count_reg = v;
        n_cfg++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] count_val, input int idle, input int budget,
                             input bit long_chain);
        int cnt;
        int sent;
        int pick;
        int k;
        drain();
        write_count(count_val);
        idle_pct = idle;
        cnt = live_count();
        sent = 0;
        if (long_chain)
            build_chain(cnt, (cnt < 16) ? cnt : 16);
        while (sent < budget)
        begin
            pick = $urandom_range(99);
            if (pick < 40)
            begin
                k = $urandom_range(1, 4);
                repeat (k)
                    send_request(CMD_LOAD_ROW, pick_node(cnt), $urandom_range(MAX_NODES - 1),
                                 rand_value(), rand_row(), 1'b0, '0);
                sent += k;
                k = $urandom_range(1, 3);
                repeat (k)
                    random_query(cnt);
                sent += k;
            end
            else if (pick < 55)
            begin
                k = $urandom_range(1, 3);
                repeat (k)
                    send_request(CMD_LOAD_VALUE, pick_node(cnt), $urandom_range(MAX_NODES - 1),
                                 rand_value(), rand_row(), 1'b0, '0);
                sent += k;
            end
            else if (pick < 70)
            begin
                k = $urandom_range(1, (cnt < 10) ? cnt : 10);
                build_chain(cnt, k);
                sent += k + 1;
            end
            else if (pick < 88)
            begin
                k = $urandom_range(1, 3);
                repeat (k)
                    random_query(cnt);
                sent += k;
            end
            else
            begin
                send_request(CMD_IGNORED, $urandom_range(MAX_NODES - 1),
                             $urandom_range(MAX_NODES - 1), rand_value(), rand_row(), 1'b0, '0);
                sent += 1;
            end
        end
    endtask

    always @(posedge clk)
    begin
        route_t want;
        if (rst_n && result_valid)
        begin
            if (route_q.size() == 0)
            begin
                errors++;
                $display("%0t: result with no query pending: reachable %0d hops %0d total %0d",
                         $time, reachable, hops, total_value);
            end
            else
            begin
                want = route_q.pop_front();
                if (reachable !== want.reach)
                begin
                    errors++;
                    $display("%0t: reachable expected %0d got %0d", $time, want.reach,
                             reachable);
                end
                if (hops !== want.hops)
                begin
                    errors++;
                    $display("%0t: hops expected %0d got %0d", $time, want.hops, hops);
                end
                if (total_value !== want.total)
                begin
                    errors++;
                    $display("%0t: total_value expected %0d got %0d", $time, want.total,
                             total_value);
                end
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        command = CMD_LOAD_VALUE;
        node = '0;
        target = '0;
        value = '0;
        row_bits = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        for (int n = 0; n < MAX_NODES; n++)
        begin
            node_val[n] = '0;
            adj_row[n] = '0;
        end
        val_written = '0;
        count_reg = COUNT_RESET;
        idle_pct = 0;
        errors = 0;
        n_queries = 0;
        n_reached = 0;
        n_loads = 0;
        n_cfg = 0;
        max_hops = 0;

        directed_rows = '{
            '{ROW_REQ, CMD_LOAD_VALUE, 0, 0, 32'h0, 64'h0, 0, 0, 0, 0},
            '{ROW_REQ, CMD_LOAD_VALUE, 63, 0, 32'hFFFF_FFFF, 64'h0, 0, 0, 0, 0},
            '{ROW_REQ, CMD_QUERY, 0, 63, 32'h0, 64'h0, 1, 0, 0, 0},
            '{ROW_REQ, CMD_QUERY, 63, 63, 32'h0, 64'h0, 1, 1, 0, 38'hFFFF_FFFF},
            '{ROW_REQ, CMD_LOAD_ROW, 0, 0, 32'h0, 64'h8000_0000_0000_0000, 0, 0, 0, 0},
            '{ROW_REQ, CMD_QUERY, 0, 63, 32'h0, 64'h0, 1, 1, 1, 38'hFFFF_FFFF},
            '{ROW_REQ, CMD_QUERY, 63, 0, 32'h0, 64'h0, 1, 0, 0, 0},
            '{ROW_CFG, CMD_LOAD_VALUE, 0, 0, 32'd4, 64'h0, 0, 0, 0, 0},
            '{ROW_REQ, CMD_LOAD_VALUE, 1, 0, 32'hFFFF_FFFF, 64'h0, 0, 0, 0, 0},
            '{ROW_REQ, CMD_LOAD_VALUE, 2, 0, 32'h1, 64'h0, 0, 0, 0, 0},
            '{ROW_REQ, CMD_LOAD_VALUE, 3, 0, 32'hFFFF_FFFF, 64'h0, 0, 0, 0, 0},
            '{ROW_REQ, CMD_LOAD_ROW, 0, 0, 32'h0, 64'hFFFF_FFFF_FFFF_FFF7, 0, 0, 0, 0},
            '{ROW_REQ, CMD_LOAD_ROW, 1, 0, 32'h0, 64'h8, 0, 0, 0, 0},
            '{ROW_REQ, CMD_LOAD_ROW, 2, 0, 32'h0, 64'h8, 0, 0, 0, 0},
            '{ROW_REQ, CMD_QUERY, 0, 3, 32'h0, 64'h0, 0, 0, 0, 0},
            '{ROW_REQ, CMD_QUERY, 3, 0, 32'h0, 64'h0, 0, 0, 0, 0},
            '{ROW_REQ, CMD_QUERY, 0, 5, 32'h0, 64'h0, 1, 0, 0, 0},
            '{ROW_REQ, CMD_QUERY, 9, 1, 32'h0, 64'h0, 1, 0, 0, 0},
            '{ROW_REQ, CMD_IGNORED, 0, 1, 32'h5, 64'h0, 0, 0, 0, 0},
            '{ROW_CFG, CMD_LOAD_VALUE, 0, 0, 32'd0, 64'h0, 0, 0, 0, 0},
            '{ROW_REQ, CMD_QUERY, 0, 0, 32'h0, 64'h0, 1, 1, 0, 0},
            '{ROW_REQ, CMD_QUERY, 0, 1, 32'h0, 64'h0, 1, 0, 0, 0},
            '{ROW_CFG, CMD_LOAD_VALUE, 0, 0, 32'd127, 64'h0, 0, 0, 0, 0},
            '{ROW_REQ, CMD_QUERY, 63, 63, 32'h0, 64'h0, 1, 1, 0, 38'hFFFF_FFFF},
            '{ROW_REQ, CMD_QUERY, 1, 3, 32'h0, 64'h0, 0, 0, 0, 0},
            '{ROW_REQ, CMD_IGNORED, 63, 63, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
              0, 0, 0, 0}
        };

        repeat (9)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CFG)
            begin
                drain();
                write_count(directed_rows[i].value[CFG_W-1:0]);
            end
            else
            begin
                send_request(directed_rows[i].cmd, directed_rows[i].src, directed_rows[i].dst,
                             directed_rows[i].value, directed_rows[i].bits,
                             directed_rows[i].known,
                             '{directed_rows[i].reach, directed_rows[i].hops,
                               directed_rows[i].total});
            end
        end

        run_phase(7'd6, 0, 10, 1'b0);
        run_phase(7'd2, 71, 8, 1'b0);
        run_phase(7'd13, 0, 10, 1'b0);
        run_phase(7'd64, 26, 6, 1'b1);
        run_phase(7'd1, 71, 6, 1'b0);
        run_phase(7'd30, 26, 8, 1'b0);
        drain();

        $display("Ran %0d queries (%0d reachable, longest %0d hops) and %0d loads",
                 n_queries, n_reached, max_hops, n_loads);
        $display("over %0d node_count settings; %0d mismatches", n_cfg, errors);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/spmvq_pkg.sv
rtl/spmvq_graph_mem.sv
rtl/spmvq_best_unit.sv
rtl/shortest_path_max_value_query.sv
tb/tb_top.sv
